FILE: hw/rtl/pzbe_pkg.sv
// shared types, constants and the bar code table for the postnet zip encoder
package pzbe_pkg;

  localparam int ZIP_W      = 17;
  localparam int NUM_DIGITS = 5;
  localparam int DIGIT_W    = 4;
  localparam int SUM_W      = 4;
  localparam int QUOT_W     = 14;
  localparam int RECIP_W    = 18;
  localparam int RECIP_SH   = 21;
  localparam int POS_W      = 3;
  localparam int BAR_W      = 5;
  localparam int GROUP_W    = 3;

  localparam logic [ZIP_W-1:0]   ZIP_LOW    = 17'd10000;
  localparam logic [ZIP_W-1:0]   ZIP_HIGH   = 17'd99999;
  // ceil(2^21 / 10): exact quotient for every 17-bit value
  localparam logic [RECIP_W-1:0] RECIP_TEN  = 18'd209716;
  localparam logic [SUM_W-1:0]   TEN        = 4'd10;
  localparam logic [POS_W-1:0]   POS_START  = 3'd0;
  localparam logic [POS_W-1:0]   POS_CHECK  = 3'd6;
  localparam logic [POS_W-1:0]   POS_END    = 3'd7;
  localparam logic [GROUP_W-1:0] GROUP_CHECK = 3'd5;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_DIGIT   = 2'd1,
    KIND_END     = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  // data handed from cell to cell
  typedef struct packed {
    logic [ZIP_W-1:0]                     value;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;
    logic [SUM_W-1:0]                     sum;
    logic                                 invalid;
  } cell_data_t;

  // five-bar pattern for one decimal digit, msb is the leftmost bar
  function automatic logic [BAR_W-1:0] bar_of(input logic [DIGIT_W-1:0] d);
    logic [BAR_W-1:0] b;
    unique case (d)
      4'd0:    b = 5'b11000;
      4'd1:    b = 5'b00011;
      4'd2:    b = 5'b00101;
      4'd3:    b = 5'b00110;
      4'd4:    b = 5'b01001;
      4'd5:    b = 5'b01010;
      4'd6:    b = 5'b01100;
      4'd7:    b = 5'b10001;
      4'd8:    b = 5'b10010;
      4'd9:    b = 5'b10100;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/pzbe_cell.sv
// one digit cell: peels the low decimal digit and keeps the running digit sum
module pzbe_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pzbe_pkg::cell_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pzbe_pkg::cell_data_t out_data
);

  logic [pzbe_pkg::ZIP_W+pzbe_pkg::RECIP_W-1:0] prod;
  logic [pzbe_pkg::QUOT_W-1:0]                  quot;
  logic [pzbe_pkg::ZIP_W-1:0]                   rem;
  logic [pzbe_pkg::DIGIT_W-1:0]                 digit;
  logic [pzbe_pkg::SUM_W:0]                     sum_raw;
  pzbe_pkg::cell_data_t                         data_next;

  // divide by ten through the reciprocal, remainder is the digit
  always_comb begin
    prod    = (pzbe_pkg::ZIP_W+pzbe_pkg::RECIP_W)'(in_data.value) *
              (pzbe_pkg::ZIP_W+pzbe_pkg::RECIP_W)'(pzbe_pkg::RECIP_TEN);
    quot    = prod[pzbe_pkg::RECIP_SH +: pzbe_pkg::QUOT_W];
    rem     = in_data.value - {quot, 3'b000} - {2'b00, quot, 1'b0};
    digit   = rem[pzbe_pkg::DIGIT_W-1:0];
    sum_raw = {1'b0, in_data.sum} + {1'b0, digit};
    data_next.value   = pzbe_pkg::ZIP_W'(quot);
    data_next.invalid = in_data.invalid;
    // new digit enters at the top, older ones move toward the low end
    data_next.digits[pzbe_pkg::NUM_DIGITS-1] = digit;
    for (int i = 0; i < pzbe_pkg::NUM_DIGITS-1; i++) begin
      data_next.digits[i] = in_data.digits[i+1];
    end
    // running sum kept mod 10
    if (sum_raw >= {1'b0, pzbe_pkg::TEN}) begin
      data_next.sum = pzbe_pkg::SUM_W'(sum_raw - {1'b0, pzbe_pkg::TEN});
    end else begin
      data_next.sum = sum_raw[pzbe_pkg::SUM_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sum < pzbe_pkg::TEN))
    else $error("cell digit sum out of range");

endmodule

FILE: hw/rtl/pzbe_emitter.sv
// result emitter: turns one digit set into the frame, digit and check results, or one invalid result
module pzbe_emitter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pzbe_pkg::cell_data_t in_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // bar_pattern[4:0], group_index[7:5]
  output logic [1:0]           m_tuser,   // item_kind[1:0]
  output logic                 m_tlast
);

  pzbe_pkg::cell_data_t           held;
  logic                           busy;
  logic [pzbe_pkg::POS_W-1:0]     pos;
  logic                           load;
  logic                           last_now;
  logic [pzbe_pkg::DIGIT_W-1:0]   check;
  logic [pzbe_pkg::DIGIT_W-1:0]   sel_digit;
  logic [pzbe_pkg::POS_W-1:0]     digit_idx;
  pzbe_pkg::kind_t                kind_next;
  logic [pzbe_pkg::BAR_W-1:0]     bar_next;
  logic [pzbe_pkg::GROUP_W-1:0]   group_next;

  assign load     = !m_tvalid || m_tready;
  assign last_now = held.invalid || (pos == pzbe_pkg::POS_END);
  assign in_ready = !busy || (load && last_now);

  // check digit and the result for the current position
  always_comb begin
    if (held.sum == '0) begin
      check = '0;
    end else begin
      check = pzbe_pkg::TEN - held.sum;
    end
    digit_idx = pos - 3'd1;
    // digits[4] holds the high zip digit
    sel_digit = held.digits[3'(pzbe_pkg::NUM_DIGITS-1) - digit_idx];
    bar_next   = '0;
    group_next = '0;
    if (held.invalid) begin
      kind_next = pzbe_pkg::KIND_INVALID;
    end else if (pos == pzbe_pkg::POS_START) begin
      kind_next = pzbe_pkg::KIND_START;
    end else if (pos == pzbe_pkg::POS_END) begin
      kind_next = pzbe_pkg::KIND_END;
    end else if (pos == pzbe_pkg::POS_CHECK) begin
      kind_next  = pzbe_pkg::KIND_DIGIT;
      bar_next   = pzbe_pkg::bar_of(check);
      group_next = pzbe_pkg::GROUP_CHECK;
    end else begin
      kind_next  = pzbe_pkg::KIND_DIGIT;
      bar_next   = pzbe_pkg::bar_of(sel_digit);
      group_next = digit_idx;
    end
  end

  // held item, position counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= busy;
        if (busy) begin
          pos <= last_now ? pzbe_pkg::POS_START : pos + 3'd1;
        end
      end
      if (in_ready) begin
        busy <= in_valid;
      end
    end
    if (in_ready && in_valid) begin
      held <= in_data;
    end
    if (load && busy) begin
      m_tdata <= {group_next, bar_next};
      m_tuser <= kind_next;
      m_tlast <= last_now;
    end
  end

  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == pzbe_pkg::KIND_INVALID) |-> m_tlast)
    else $error("invalid result not marked last");

  a_digit_two_bars: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == pzbe_pkg::KIND_DIGIT) |->
      ($countones(m_tdata[4:0]) == 2 && !m_tlast))
    else $error("digit group malformed");

  a_end_follows_check: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser == pzbe_pkg::KIND_DIGIT &&
     m_tdata[7:5] == pzbe_pkg::GROUP_CHECK) |=>
      (!m_tvalid || m_tuser == pzbe_pkg::KIND_END))
    else $error("end frame bar must follow check digit");

endmodule

FILE: hw/rtl/postnet_zip_barcode_encoder_unit.sv
// postnet zip bar code encoder: digit cell chain followed by the result emitter
// path: a request passes the 5 cells, then the emitter's held item and its output register
// throughput: one result per cycle while m_tready is high; a valid zip gives eight results,
//   an invalid zip one result, all through the emitter's single output register
// reset: synchronous, clears all valid flags, the emitter busy flag and position; no other state
module postnet_zip_barcode_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // zip_code[16:0], zero fill [23:17]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // bar_pattern[4:0], group_index[7:5]
  output logic [1:0]  m_tuser,   // item_kind[1:0]
  output logic        m_tlast    // last_result
);

  pzbe_pkg::cell_data_t               chain_data  [pzbe_pkg::NUM_DIGITS+1];
  logic [pzbe_pkg::NUM_DIGITS:0]      chain_valid;
  logic [pzbe_pkg::NUM_DIGITS:0]      chain_ready;
  logic [pzbe_pkg::ZIP_W-1:0]         zip_code;

  // range check and chain entry
  always_comb begin
    zip_code                 = s_tdata[pzbe_pkg::ZIP_W-1:0];
    chain_data[0].value      = zip_code;
    chain_data[0].digits     = '0;
    chain_data[0].sum        = '0;
    chain_data[0].invalid    = (zip_code < pzbe_pkg::ZIP_LOW) ||
                               (zip_code > pzbe_pkg::ZIP_HIGH);
  end

  assign chain_valid[0] = s_tvalid;
  assign s_tready       = chain_ready[0];

  // one cell per zip digit, low digit first
  for (genvar g = 0; g < pzbe_pkg::NUM_DIGITS; g++) begin : g_cell
    pzbe_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  // serialize the eight results of a valid zip, or the single invalid result
  pzbe_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[pzbe_pkg::NUM_DIGITS]),
    .in_ready (chain_ready[pzbe_pkg::NUM_DIGITS]),
    .in_data  (chain_data[pzbe_pkg::NUM_DIGITS]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: dv/postnet_zip_barcode_encoder_unit_tb.sv
// testbench for the postnet zip bar code encoder: random stream traffic checked by a predictor
`timescale 1ns / 100ps

module postnet_zip_barcode_encoder_unit_tb;

  // one zip request waiting to be sent, optionally after the encoder has drained
  typedef struct {
    logic [pzbe_pkg::ZIP_W-1:0] zip;
    bit                         drain_first;
  } zip_request_t;

  // one expected bar code result
  typedef struct packed {
    pzbe_pkg::kind_t              kind;
    logic [pzbe_pkg::BAR_W-1:0]   bars;
    logic [pzbe_pkg::GROUP_W-1:0] group;
    logic                         last;
  } bar_result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_TWO_OF_THREE,
    READY_BURST_STALL
  } stall_style_t;

  // bar groups for digits 9 down to 0, digit 0 in the lowest five bits
  localparam logic [10*pzbe_pkg::BAR_W-1:0] DIGIT_BARS = {
    5'b10100, 5'b10010, 5'b10001, 5'b01100, 5'b01010,
    5'b01001, 5'b00110, 5'b00101, 5'b00011, 5'b11000
  };
  localparam int NUM_RANDOM   = 288;
  localparam int MAX_PRINTED  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // zip_code[16:0], zero fill [23:17]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // bar_pattern[4:0], group_index[7:5]
  logic [1:0]  m_tuser;        // item_kind[1:0]
  logic        m_tlast;

  zip_request_t pending_zips[$];
  bar_result_t  expected_bars[$];
  zip_request_t next_req;
  int           mismatch_count = 0;
  logic         in_taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  stall_style_t stall_mode = READY_ALWAYS;
  int           mode_left = 0;
  int           stall_left = 0;
  int unsigned  ready_phase = 0;

  postnet_zip_barcode_encoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic bar_result_t make_result(pzbe_pkg::kind_t kind,
                                              logic [pzbe_pkg::BAR_W-1:0] bars,
                                              logic [pzbe_pkg::GROUP_W-1:0] group,
                                              logic last);
    bar_result_t r;
    r.kind  = kind;
    r.bars  = bars;
    r.group = group;
    r.last  = last;
    return r;
  endfunction

  // work out the bar code results for one zip and queue them
  task automatic predict_postnet(input logic [pzbe_pkg::ZIP_W-1:0] zip);
    int unsigned rest;
    int unsigned digit_sum;
    int unsigned check;
    int unsigned digit_val [pzbe_pkg::NUM_DIGITS];
    if (zip < pzbe_pkg::ZIP_LOW || zip > pzbe_pkg::ZIP_HIGH) begin
      expected_bars.push_back(make_result(pzbe_pkg::KIND_INVALID, '0, '0, 1'b1));
      return;
    end
    rest = zip;
    digit_sum = 0;
    for (int i = pzbe_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
      digit_val[i] = rest % 10;
      rest = rest / 10;
      digit_sum += digit_val[i];
    end
    check = (10 - digit_sum % 10) % 10;
    expected_bars.push_back(make_result(pzbe_pkg::KIND_START, '0, '0, 1'b0));
    for (int i = 0; i < pzbe_pkg::NUM_DIGITS; i++)
      expected_bars.push_back(make_result(pzbe_pkg::KIND_DIGIT,
                                          DIGIT_BARS[digit_val[i]*pzbe_pkg::BAR_W +:
                                                     pzbe_pkg::BAR_W],
                                          pzbe_pkg::GROUP_W'(i), 1'b0));
    expected_bars.push_back(make_result(pzbe_pkg::KIND_DIGIT,
                                        DIGIT_BARS[check*pzbe_pkg::BAR_W +: pzbe_pkg::BAR_W],
                                        pzbe_pkg::GROUP_CHECK, 1'b0));
    expected_bars.push_back(make_result(pzbe_pkg::KIND_END, '0, '0, 1'b1));
  endtask

  task automatic add_zip(input int unsigned zip, input bit drain_first);
    zip_request_t req;
    req.zip = zip[pzbe_pkg::ZIP_W-1:0];
    req.drain_first = drain_first;
    pending_zips.push_back(req);
  endtask

  // request side: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // hold the current request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_zips.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_zips[0].drain_first && expected_bars.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        next_req = pending_zips.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, next_req.zip};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 19);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // result side: stall style is picked anew at random each time mode_left runs out
  always @(negedge clk) begin
    if (!rst) begin
      if (mode_left == 0) begin
        stall_mode = stall_style_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      ready_phase++;
      case (stall_mode)
        READY_ALWAYS: begin
          m_tready <= 1'b1;
        end
        READY_COIN: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        READY_TWO_OF_THREE: begin
          m_tready <= (ready_phase % 3 != 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 10);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // accept requests into the predictor and check each result against the oldest expectation
  always @(posedge clk) begin
    bar_result_t want;
    in_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_postnet(s_tdata[pzbe_pkg::ZIP_W-1:0]);
      if (m_tvalid && m_tready) begin
        if (expected_bars.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d bars %b group %0d last %0b",
                                    m_tuser, m_tdata[4:0], m_tdata[7:5], m_tlast));
        end else begin
          want = expected_bars.pop_front();
          if (m_tuser !== want.kind)
            report_mismatch($sformatf("item_kind %0d, expected %0d", m_tuser, want.kind));
          if (m_tdata[4:0] !== want.bars)
            report_mismatch($sformatf("bar_pattern %b, expected %b", m_tdata[4:0], want.bars));
          if (m_tdata[7:5] !== want.group)
            report_mismatch($sformatf("group_index %0d, expected %0d", m_tdata[7:5],
                                      want.group));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last_result %0b, expected %0b", m_tlast, want.last));
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    // range edges, out of range codes and digit sums that wrap the check digit
    add_zip(0, 1'b0);
    add_zip(1, 1'b0);
    add_zip(9999, 1'b0);
    add_zip(10000, 1'b0);
    add_zip(99999, 1'b0);
    add_zip(100000, 1'b0);
    add_zip(131071, 1'b0);
    add_zip(65536, 1'b0);
    add_zip(12345, 1'b0);
    add_zip(67890, 1'b0);
    add_zip(19000, 1'b0);
    add_zip(55000, 1'b0);
    add_zip(24680, 1'b0);
    add_zip(13579, 1'b0);
    add_zip(98765, 1'b1);
    add_zip(11111, 1'b0);
    add_zip(50505, 1'b0);
    add_zip(30417, 1'b0);
    add_zip(82633, 1'b0);
    add_zip(71942, 1'b0);
    add_zip(43210, 1'b0);
    add_zip(86421, 1'b0);
    // mostly valid codes, some out of range on either side
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0:       add_zip($urandom_range(0, 9999), i == NUM_RANDOM / 2);
        1:       add_zip($urandom_range(100000, 131071), i == NUM_RANDOM / 2);
        default: add_zip($urandom_range(10000, 99999), i == NUM_RANDOM / 2);
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_zips.size() != 0 || s_tvalid)
      @(posedge clk);
    while (expected_bars.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pzbe_pkg.sv
hw/rtl/pzbe_cell.sv
hw/rtl/pzbe_emitter.sv
hw/rtl/postnet_zip_barcode_encoder_unit.sv
dv/postnet_zip_barcode_encoder_unit_tb.sv
